### rtl/mids_pkg.sv
// ---------------------------------------------------------------------------
// mids_pkg: shared types and constants for the minimum-image distance block
// Payload structs, register indexes, reset values and the saturation helper.
// ---------------------------------------------------------------------------
package mids_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_BOX_XX   = 3'd0;
    localparam logic [2:0] REG_BOX_YY   = 3'd1;
    localparam logic [2:0] REG_BOX_ZZ   = 3'd2;
    localparam logic [2:0] REG_BOX_YX   = 3'd3;
    localparam logic [2:0] REG_BOX_ZX   = 3'd4;
    localparam logic [2:0] REG_BOX_ZY   = 3'd5;
    localparam logic [2:0] REG_INV_DIAG = 3'd6;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 63;
    localparam int RecipWidth    = 21;

    // Reset values: unit box, no tilt, reciprocals of 1.0 in Q1.20
    localparam logic [30:0]           BOX_DIAG_RESET = 31'd65536;
    localparam logic [RecipWidth-1:0] RECIP_RESET    = 21'h10_0000;

    // Half an integer step of the Q16.16 x Q1.20 product (36 fraction bits)
    localparam logic signed [54:0] ROUND_HALF = 55'sh8_0000_0000;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] wrapped_dx;
        logic signed [31:0] wrapped_dy;
        logic signed [31:0] wrapped_dz;
        logic [63:0]        distance_squared;
    } t_out_item;

    // One box vector: its diagonal entry, the tilts applied to the two
    // other components, and the reciprocal of the diagonal
    typedef struct packed {
        logic [30:0]           diag;
        logic signed [31:0]    tilt_b;
        logic signed [31:0]    tilt_c;
        logic [RecipWidth-1:0] recip;
    } t_axis_cfg;

    // Components entering an axis stage (own component a, others b and c)
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] c;
    } t_comp_wide;

    // Components leaving an axis stage, saturated to Q16.16
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } t_comp;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] res;
        if (v[51:31] != {21{v[51]}}) begin
            res = v[51] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### rtl/mids_axis.sv
// ---------------------------------------------------------------------------
// mids_axis: one box-vector wrap step, four register stages
// Forms the shift count of the own component, then subtracts count times the
// box vector from all three components with saturation.
// ---------------------------------------------------------------------------
module mids_axis import mids_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_axis_cfg  i_cfg,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_comp_wide i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_comp      o_data
);

    localparam int Stages = 4;

    logic [Stages-1:0] r_valid;
    logic [Stages-1:0] n_valid;
    logic [Stages:0]   w_load;

    // A stage loads when it is empty or its contents move on
    always_comb begin
        w_load[Stages] = !i_stall;
        for (int k = Stages - 1; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
    end

    assign n_valid = {r_valid[Stages-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < Stages; k++) begin
                if (w_load[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    assign o_stall = !w_load[0];
    assign o_valid = r_valid[Stages-1];

    // Stage 1: own component times reciprocal
    logic signed [32:0] w_in_a;
    logic signed [21:0] w_recip;
    logic signed [54:0] w_prod;
    logic signed [54:0] r1_prod;
    logic signed [32:0] r1_a;
    logic signed [32:0] r1_b;
    logic signed [32:0] r1_c;

    assign w_in_a  = i_data.a;
    assign w_recip = $signed({1'b0, i_cfg.recip});
    assign w_prod  = w_in_a * w_recip;

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r1_prod <= w_prod;
            r1_a    <= i_data.a;
            r1_b    <= i_data.b;
            r1_c    <= i_data.c;
        end
    end

    // Stage 2: round to integer, ties away from zero; a negative product
    // takes one off the half step so the arithmetic shift rounds outward
    logic signed [54:0] w_round;
    logic signed [18:0] r2_cnt;
    logic signed [32:0] r2_a;
    logic signed [32:0] r2_b;
    logic signed [32:0] r2_c;

    assign w_round = r1_prod + ROUND_HALF - {54'd0, r1_prod[54]};

    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r2_cnt <= w_round[54:36];
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_c   <= r1_c;
        end
    end

    // Stage 3: count times each entry of the box vector
    logic signed [31:0] w_diag;
    logic signed [50:0] w_pa;
    logic signed [50:0] w_pb;
    logic signed [50:0] w_pc;
    logic signed [50:0] r3_pa;
    logic signed [50:0] r3_pb;
    logic signed [50:0] r3_pc;
    logic signed [32:0] r3_a;
    logic signed [32:0] r3_b;
    logic signed [32:0] r3_c;

    assign w_diag = $signed({1'b0, i_cfg.diag});
    assign w_pa   = w_diag * r2_cnt;
    assign w_pb   = i_cfg.tilt_b * r2_cnt;
    assign w_pc   = i_cfg.tilt_c * r2_cnt;

    always_ff @(posedge i_clk) begin
        if (w_load[2]) begin
            r3_pa <= w_pa;
            r3_pb <= w_pb;
            r3_pc <= w_pc;
            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_c  <= r2_c;
        end
    end

    // Stage 4: subtract and saturate
    logic signed [51:0] w_da;
    logic signed [51:0] w_db;
    logic signed [51:0] w_dc;
    t_comp              r4_out;

    assign w_da = r3_a - r3_pa;
    assign w_db = r3_b - r3_pb;
    assign w_dc = r3_c - r3_pc;

    always_ff @(posedge i_clk) begin
        if (w_load[3]) begin
            r4_out.a <= sat32(w_da);
            r4_out.b <= sat32(w_db);
            r4_out.c <= sat32(w_dc);
        end
    end

    assign o_data = r4_out;

endmodule

### rtl/min_image_distance_sq.sv
// ---------------------------------------------------------------------------
// min_image_distance_sq: minimum-image displacement in a triclinic box
// Wraps the pair displacement by the z, y and x box vectors in turn and
// returns the wrapped vector with its squared length.
// ---------------------------------------------------------------------------
// Usage: one pair is taken every clock cycle unless the output side stalls.
// The pipeline runs in order: one stage forms the difference, each of the
// three box vectors takes four stages (product with the reciprocal,
// rounding of the shift count, box products, subtract with saturation), one
// stage squares the components and the output register holds the sum.
// A stall on the output only holds the stages that are full; empty stages
// keep filling. Write the box registers only while no transaction is in
// flight. The inverse diagonals are used as given and are not checked
// against the box lengths.
module min_image_distance_sq import mids_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data
);

    // Configuration registers
    logic [30:0]           r_box_xx;
    logic [30:0]           r_box_yy;
    logic [30:0]           r_box_zz;
    logic signed [31:0]    r_box_yx;
    logic signed [31:0]    r_box_zx;
    logic signed [31:0]    r_box_zy;
    logic [RecipWidth-1:0] r_recip_x;
    logic [RecipWidth-1:0] r_recip_y;
    logic [RecipWidth-1:0] r_recip_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_xx  <= BOX_DIAG_RESET;
            r_box_yy  <= BOX_DIAG_RESET;
            r_box_zz  <= BOX_DIAG_RESET;
            r_box_yx  <= '0;
            r_box_zx  <= '0;
            r_box_zy  <= '0;
            r_recip_x <= RECIP_RESET;
            r_recip_y <= RECIP_RESET;
            r_recip_z <= RECIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BOX_XX:   r_box_xx <= i_cfg_data[30:0];
                REG_BOX_YY:   r_box_yy <= i_cfg_data[30:0];
                REG_BOX_ZZ:   r_box_zz <= i_cfg_data[30:0];
                REG_BOX_YX:   r_box_yx <= i_cfg_data[31:0];
                REG_BOX_ZX:   r_box_zx <= i_cfg_data[31:0];
                REG_BOX_ZY:   r_box_zy <= i_cfg_data[31:0];
                REG_INV_DIAG: begin
                    r_recip_x <= i_cfg_data[20:0];
                    r_recip_y <= i_cfg_data[41:21];
                    r_recip_z <= i_cfg_data[62:42];
                end
                default: ;
            endcase
        end
    end

    // Stage loads, back to front
    logic r_diff_valid;
    logic r_sq_valid;
    logic r_out_valid;
    logic w_load_out;
    logic w_load_sq;
    logic w_load_diff;
    logic w_z_stall;
    logic w_y_stall;
    logic w_x_stall;
    logic w_z_valid;
    logic w_y_valid;
    logic w_x_valid;

    assign w_load_out  = !r_out_valid || !i_out_stall;
    assign w_load_sq   = !r_sq_valid || w_load_out;
    assign w_load_diff = !r_diff_valid || !w_z_stall;
    assign o_in_stall  = !w_load_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_valid <= 1'b0;
            r_sq_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_load_diff) begin
                r_diff_valid <= i_in_valid;
            end
            if (w_load_sq) begin
                r_sq_valid <= w_x_valid;
            end
            if (w_load_out) begin
                r_out_valid <= r_sq_valid;
            end
        end
    end

    // Difference first - second, exact at 33 bits
    t_comp_wide r_diff;

    always_ff @(posedge i_clk) begin
        if (w_load_diff) begin
            r_diff.a <= {i_in_data.first_z[31], i_in_data.first_z}
                      - {i_in_data.second_z[31], i_in_data.second_z};
            r_diff.b <= {i_in_data.first_y[31], i_in_data.first_y}
                      - {i_in_data.second_y[31], i_in_data.second_y};
            r_diff.c <= {i_in_data.first_x[31], i_in_data.first_x}
                      - {i_in_data.second_x[31], i_in_data.second_x};
        end
    end

    // Z vector: own z, then y (tilt zy) and x (tilt zx)
    t_axis_cfg w_cfg_z;
    t_comp     w_z_out;

    assign w_cfg_z = '{diag: r_box_zz, tilt_b: r_box_zy, tilt_c: r_box_zx,
                       recip: r_recip_z};

    mids_axis u_axis_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg_z),
        .i_valid (r_diff_valid),
        .o_stall (w_z_stall),
        .i_data  (r_diff),
        .o_valid (w_z_valid),
        .i_stall (w_y_stall),
        .o_data  (w_z_out)
    );

    // Y vector: own y, then x (tilt yx); z passes unchanged
    t_axis_cfg  w_cfg_y;
    t_comp_wide w_y_in;
    t_comp      w_y_out;

    assign w_cfg_y = '{diag: r_box_yy, tilt_b: r_box_yx, tilt_c: 32'sd0,
                       recip: r_recip_y};
    assign w_y_in.a = {w_z_out.b[31], w_z_out.b};
    assign w_y_in.b = {w_z_out.c[31], w_z_out.c};
    assign w_y_in.c = {w_z_out.a[31], w_z_out.a};

    mids_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg_y),
        .i_valid (w_z_valid),
        .o_stall (w_y_stall),
        .i_data  (w_y_in),
        .o_valid (w_y_valid),
        .i_stall (w_x_stall),
        .o_data  (w_y_out)
    );

    // X vector: own x only
    t_axis_cfg  w_cfg_x;
    t_comp_wide w_x_in;
    t_comp      w_x_out;

    assign w_cfg_x = '{diag: r_box_xx, tilt_b: 32'sd0, tilt_c: 32'sd0,
                       recip: r_recip_x};
    assign w_x_in.a = {w_y_out.b[31], w_y_out.b};
    assign w_x_in.b = {w_y_out.a[31], w_y_out.a};
    assign w_x_in.c = {w_y_out.c[31], w_y_out.c};

    mids_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg_x),
        .i_valid (w_y_valid),
        .o_stall (w_x_stall),
        .i_data  (w_x_in),
        .o_valid (w_x_valid),
        .i_stall (!w_load_sq),
        .o_data  (w_x_out)
    );

    // Squares of the wrapped components
    logic signed [63:0] w_sq_x;
    logic signed [63:0] w_sq_y;
    logic signed [63:0] w_sq_z;
    logic [63:0]        r_sq_x;
    logic [63:0]        r_sq_y;
    logic [63:0]        r_sq_z;
    logic signed [31:0] r_wx;
    logic signed [31:0] r_wy;
    logic signed [31:0] r_wz;

    assign w_sq_x = w_x_out.a * w_x_out.a;
    assign w_sq_y = w_x_out.b * w_x_out.b;
    assign w_sq_z = w_x_out.c * w_x_out.c;

    always_ff @(posedge i_clk) begin
        if (w_load_sq) begin
            r_sq_x <= unsigned'(w_sq_x);
            r_sq_y <= unsigned'(w_sq_y);
            r_sq_z <= unsigned'(w_sq_z);
            r_wx   <= w_x_out.a;
            r_wy   <= w_x_out.b;
            r_wz   <= w_x_out.c;
        end
    end

    // Sum with saturation at the 64-bit maximum
    logic [65:0] w_sum;
    t_out_item   r_out;

    assign w_sum = {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_z};

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.wrapped_dx       <= r_wx;
            r_out.wrapped_dy       <= r_wy;
            r_out.wrapped_dz       <= r_wz;
            r_out.distance_squared <= (w_sum[65:64] != 2'b00) ? '1 : w_sum[63:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
